FILE: sv/pc_pkg.sv
package pc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam int EDGE_W       = 17;
   localparam int CROSS_W      = 48;
   localparam int MOMENT_W     = 64;
   localparam int DEN_W        = 50;
   localparam int DIV_CNT_W    = $clog2(MOMENT_W);

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW   = 2'd2;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [15:0] centroid_x;
      logic signed [15:0] centroid_y;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic                     acc;
      logic                     last;
      logic [1:0]               cls;
      logic signed [15:0]       ref_x;
      logic signed [15:0]       ref_y;
      logic signed [EDGE_W-1:0] e1x;
      logic signed [EDGE_W-1:0] e1y;
      logic signed [EDGE_W-1:0] e2x;
      logic signed [EDGE_W-1:0] e2y;
   } job_type;

endpackage

FILE: sv/polygon_centroid_core.sv
// Streaming polygon centroid by triangle fan. Send one vertex per request in signed
// Q12.4 with last_vertex set on the final one; one result follows each last vertex.
// Vertices are accepted while the four-entry job queue has room. From the third vertex
// of a polygon on, each vertex is a job for the back end, which takes it when idle and
// then works it through states M0 to M5 on its single shared 35x18 multiplier, so it
// takes no new vertex before it is through with the last. The last vertex then passes
// the classification state, and for a polygon with nonzero area the bit-serial divider
// and sign restore and saturation; the output register is loaded once the output is
// free. Status 1 flags fewer than three vertices or zero area, status 2 flags vertices
// beyond MAX_VERTICES; both give zero centroids.
module polygon_centroid_core import pc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    job_push, job_pop, queue_full, queue_empty;
   job_type push_job, pop_job;

   pc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .job_push   (job_push),
      .job        (push_job),
      .queue_full (queue_full)
   );

   pc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   pc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!queue_empty),
      .job       (pop_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/pc_queue.sv
module pc_queue import pc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue pop while empty");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

FILE: sv/pc_front.sv
module pc_front import pc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    job_push,
   output job_type job,
   input  logic    queue_full
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic signed [15:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   logic               accept, over, acc;
   logic [COUNT_W-1:0] count_new;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign over      = (count_ff == COUNT_W'(MAX_VERTICES));
   assign acc       = !over && (count_ff >= COUNT_W'(2));
   assign count_new = over ? count_ff : count_ff + 1'b1;

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      ref_x_in  = ref_x_ff;
      ref_y_in  = ref_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (accept) begin
         if (over) begin
            ovf_in = 1'b1;
         end else begin
            if (count_ff == '0) begin
               ref_x_in = req_data.vertex_x;
               ref_y_in = req_data.vertex_y;
            end
            prev_x_in = req_data.vertex_x;
            prev_y_in = req_data.vertex_y;
            count_in  = count_new;
         end
         if (req_data.last_vertex) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_comb begin
      job.acc   = acc;
      job.last  = req_data.last_vertex;
      job.ref_x = ref_x_in;
      job.ref_y = ref_y_in;
      job.e1x   = {prev_x_ff[15], prev_x_ff} - {ref_x_ff[15], ref_x_ff};
      job.e1y   = {prev_y_ff[15], prev_y_ff} - {ref_y_ff[15], ref_y_ff};
      job.e2x   = {req_data.vertex_x[15], req_data.vertex_x} - {ref_x_ff[15], ref_x_ff};
      job.e2y   = {req_data.vertex_y[15], req_data.vertex_y} - {ref_y_ff[15], ref_y_ff};
      if (over || ovf_ff) begin
         job.cls = STATUS_OVERFLOW;
      end else if (count_new < COUNT_W'(3)) begin
         job.cls = STATUS_DEGENERATE;
      end else begin
         job.cls = STATUS_OK;
      end
   end

   assign job_push = accept && (acc || req_data.last_vertex);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_x_ff  <= ref_x_in;
      ref_y_ff  <= ref_y_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
   end

endmodule

FILE: sv/pc_back.sv
module pc_back import pc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M0   = 4'd1;
   localparam logic [3:0] S_M1   = 4'd2;
   localparam logic [3:0] S_M2   = 4'd3;
   localparam logic [3:0] S_M3   = 4'd4;
   localparam logic [3:0] S_M4   = 4'd5;
   localparam logic [3:0] S_M5   = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_FIX  = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   logic [3:0]                 state_ff, state_in;
   job_type                    work_ff, work_in;
   logic signed [52:0]         prod_ff, prod_in;
   logic signed [33:0]         p0_ff, p0_in;
   logic signed [34:0]         d_ff, d_in;
   logic signed [CROSS_W-1:0]  cross_ff, cross_in;
   logic signed [MOMENT_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [MOMENT_W-1:0]        num_x_ff, num_x_in, num_y_ff, num_y_in;
   logic [DEN_W-1:0]           rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic                       neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [DIV_CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   rsp_type                    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   logic signed [34:0]         mul_a;
   logic signed [17:0]         mul_b;
   logic signed [17:0]         sum_x, sum_y;
   logic signed [DEN_W-1:0]    cross3;
   logic [DEN_W:0]             sh_x, sh_y;
   logic                       ge_x, ge_y;
   logic                       out_free, emit_fire;

   function automatic logic signed [15:0] fix_centroid(input logic [MOMENT_W-1:0] q,
                                                       input logic neg,
                                                       input logic signed [15:0] base);
      logic signed [65:0] v;
      logic signed [65:0] s;
      v = $signed({2'b00, q});
      if (neg) begin
         v = -v;
      end
      s = v + {{50{base[15]}}, base};
      if (s > 66'sd32767) begin
         return 16'sh7fff;
      end else if (s < -66'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   assign sum_x    = {work_ff.e1x[16], work_ff.e1x} + {work_ff.e2x[16], work_ff.e2x};
   assign sum_y    = {work_ff.e1y[16], work_ff.e1y} + {work_ff.e2y[16], work_ff.e2y};
   assign cross3   = {{2{cross_ff[CROSS_W-1]}}, cross_ff}
                   + {cross_ff[CROSS_W-1], cross_ff, 1'b0};
   assign sh_x     = {rem_x_ff, num_x_ff[MOMENT_W-1]};
   assign sh_y     = {rem_y_ff, num_y_ff[MOMENT_W-1]};
   assign ge_x     = (sh_x >= {1'b0, den_ff});
   assign ge_y     = (sh_y >= {1'b0, den_ff});
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (state_ff == S_EMIT) && out_free;
   assign job_pop  = (state_ff == S_IDLE) && job_valid;

   always_comb begin
      case (state_ff)
         S_M0: begin
            mul_a = {{18{work_ff.e1x[16]}}, work_ff.e1x};
            mul_b = {work_ff.e2y[16], work_ff.e2y};
         end
         S_M1: begin
            mul_a = {{18{work_ff.e1y[16]}}, work_ff.e1y};
            mul_b = {work_ff.e2x[16], work_ff.e2x};
         end
         S_M3: begin
            mul_a = d_ff;
            mul_b = sum_x;
         end
         S_M4: begin
            mul_a = d_ff;
            mul_b = sum_y;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      p0_in        = p0_ff;
      d_in         = d_ff;
      cross_in     = cross_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      num_x_in     = num_x_ff;
      num_y_in     = num_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      den_in       = den_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      div_cnt_in   = div_cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               work_in  = job;
               state_in = job.acc ? S_M0 : S_FIN;
            end
         end
         S_M0: begin
            state_in = S_M1;
         end
         S_M1: begin
            p0_in    = prod_ff[33:0];
            state_in = S_M2;
         end
         S_M2: begin
            d_in     = {p0_ff[33], p0_ff} - {prod_ff[33], prod_ff[33:0]};
            state_in = S_M3;
         end
         S_M3: begin
            state_in = S_M4;
         end
         S_M4: begin
            mx_in    = mx_ff + {{11{prod_ff[52]}}, prod_ff};
            state_in = S_M5;
         end
         S_M5: begin
            my_in    = my_ff + {{11{prod_ff[52]}}, prod_ff};
            cross_in = cross_ff + {{13{d_ff[34]}}, d_ff};
            state_in = work_ff.last ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (work_ff.cls == STATUS_OK && cross_ff != '0) begin
               num_x_in   = mx_ff[MOMENT_W-1] ? MOMENT_W'(-mx_ff) : MOMENT_W'(mx_ff);
               num_y_in   = my_ff[MOMENT_W-1] ? MOMENT_W'(-my_ff) : MOMENT_W'(my_ff);
               den_in     = cross3[DEN_W-1] ? DEN_W'(-cross3) : DEN_W'(cross3);
               neg_x_in   = mx_ff[MOMENT_W-1] ^ cross_ff[CROSS_W-1];
               neg_y_in   = my_ff[MOMENT_W-1] ^ cross_ff[CROSS_W-1];
               rem_x_in   = '0;
               rem_y_in   = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end else begin
               res_in.centroid_x = '0;
               res_in.centroid_y = '0;
               res_in.status     = (work_ff.cls == STATUS_OK) ? STATUS_DEGENERATE
                                                              : work_ff.cls;
               state_in          = S_EMIT;
            end
         end
         S_DIV: begin
            rem_x_in   = ge_x ? DEN_W'(sh_x - {1'b0, den_ff}) : sh_x[DEN_W-1:0];
            rem_y_in   = ge_y ? DEN_W'(sh_y - {1'b0, den_ff}) : sh_y[DEN_W-1:0];
            num_x_in   = {num_x_ff[MOMENT_W-2:0], ge_x};
            num_y_in   = {num_y_ff[MOMENT_W-2:0], ge_y};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(MOMENT_W - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            res_in.centroid_x = fix_centroid(num_x_ff, neg_x_ff, work_ff.ref_x);
            res_in.centroid_y = fix_centroid(num_y_ff, neg_y_ff, work_ff.ref_y);
            res_in.status     = STATUS_OK;
            state_in          = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               cross_in     = '0;
               mx_in        = '0;
               my_in        = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cross_ff     <= '0;
         mx_ff        <= '0;
         my_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cross_ff     <= cross_in;
         mx_ff        <= mx_in;
         my_ff        <= my_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      prod_ff    <= prod_in;
      p0_ff      <= p0_in;
      d_ff       <= d_in;
      num_x_ff   <= num_x_in;
      num_y_ff   <= num_y_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      den_ff     <= den_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      div_cnt_ff <= div_cnt_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (cross_ff == '0 && mx_ff == '0 && my_ff == '0))
      else $error("accumulators not cleared after result");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (den_ff != '0))
      else $error("division with zero divisor");
   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK)
         |-> (rsp_ff.centroid_x == '0 && rsp_ff.centroid_y == '0))
      else $error("nonzero centroid on failed polygon");
`endif

endmodule

FILE: bench/tb_polygon_centroid_core.sv
module tb_polygon_centroid_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pc_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 9;
   localparam int ITEM_GOAL = 1900;
   localparam int SMALL_GOAL = ITEM_GOAL - MAX_VERTICES - 1;
   localparam int IDLE_PCT = 33;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 100;
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_LIMIT = 200;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_LOCAL,
      SHAPE_LINE,
      SHAPE_CORNER,
      SHAPE_BOX
   } shape_kind_type;

   class centroid_scoreboard_type;
      rsp_type centroid_q[$];
      int      errors;
      int      ref_x, ref_y, prev_x, prev_y;
      int      vertex_count;
      longint  cross_sum, moment_x, moment_y;
      bit      overflow_seen;

      function void clear_polygon();
         ref_x = 0;
         ref_y = 0;
         prev_x = 0;
         prev_y = 0;
         vertex_count = 0;
         cross_sum = 0;
         moment_x = 0;
         moment_y = 0;
         overflow_seen = 1'b0;
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function void add_vertex(req_type v);
         longint  e1x, e1y, e2x, e2y, area, den;
         rsp_type r;
         if (vertex_count >= MAX_VERTICES) begin
            overflow_seen = 1'b1;
         end else begin
            if (vertex_count == 0) begin
               ref_x = int'(v.vertex_x);
               ref_y = int'(v.vertex_y);
            end else if (vertex_count >= 2) begin
               e1x = prev_x - ref_x;
               e1y = prev_y - ref_y;
               e2x = int'(v.vertex_x) - ref_x;
               e2y = int'(v.vertex_y) - ref_y;
               area = e1x * e2y - e1y * e2x;
               cross_sum += area;
               moment_x += area * (e1x + e2x);
               moment_y += area * (e1y + e2y);
            end
            prev_x = int'(v.vertex_x);
            prev_y = int'(v.vertex_y);
            vertex_count++;
         end
         if (!v.last_vertex) return;
         r = '0;
         if (overflow_seen) begin
            r.status = STATUS_OVERFLOW;
         end else if (vertex_count < 3 || cross_sum == 0) begin
            r.status = STATUS_DEGENERATE;
         end else begin
            den = 3 * cross_sum;
            r.centroid_x = 16'(clamp16(ref_x + moment_x / den));
            r.centroid_y = 16'(clamp16(ref_y + moment_y / den));
            r.status = STATUS_OK;
         end
         centroid_q.push_back(r);
         clear_polygon();
      endfunction

      function void report(string field, logic signed [15:0] want, logic signed [15:0] got);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_centroid(rsp_type got);
         rsp_type want;
         if (centroid_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result with none expected: expected nothing, got %p", $time, got);
            return;
         end
         want = centroid_q.pop_front();
         if (got.centroid_x !== want.centroid_x)
            report("centroid_x", want.centroid_x, got.centroid_x);
         if (got.centroid_y !== want.centroid_y)
            report("centroid_y", want.centroid_y, got.centroid_y);
         if (got.status !== want.status)
            report("status", 16'(want.status), 16'(got.status));
      endfunction

      function int pending();
         return centroid_q.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   centroid_scoreboard_type centroids = new();
   bit steady = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int small_items = 0;

   polygon_centroid_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int corner_value();
      case ($urandom_range(0, 6))
         0: return -32768;
         1: return -32767;
         2: return -1;
         3: return 0;
         4: return 1;
         5: return 32766;
         default: return 32767;
      endcase
   endfunction

   task automatic send_vertex(input int x, input int y, input bit last);
      req_type v;
      bit      taken;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      v.vertex_x = x[15:0];
      v.vertex_y = y[15:0];
      v.last_vertex = last;
      req_data <= v;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      centroids.add_vertex(v);
   endtask

   task automatic wait_for_centroids();
      req_valid <= 1'b0;
      while (centroids.pending() != 0) @(posedge clock);
   endtask

   task automatic send_polygon(input shape_kind_type shape, input int n);
      int cx, cy, dx, dy, w, h, x, y, j;
      bit flip;
      cx = rand_between(-16000, 16000);
      cy = rand_between(-16000, 16000);
      dx = rand_between(-300, 300);
      dy = rand_between(-300, 300);
      w = rand_between(1, 16000);
      h = rand_between(1, 16000);
      flip = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
         case (shape)
            SHAPE_WIDE: begin
               x = rand_between(-32768, 32767);
               y = rand_between(-32768, 32767);
            end
            SHAPE_LOCAL: begin
               x = 2 * cx + rand_between(-255, 255);
               y = 2 * cy + rand_between(-255, 255);
            end
            SHAPE_LINE: begin
               x = cx + k * dx;
               y = cy + k * dy;
            end
            SHAPE_CORNER: begin
               x = corner_value();
               y = corner_value();
            end
            default: begin
               j = flip ? 3 - (k % 4) : k % 4;
               x = (j == 1 || j == 2) ? cx + w : cx;
               y = (j >= 2) ? cy + h : cy;
            end
         endcase
         send_vertex(x, y, k == n - 1);
      end
   endtask

   task automatic send_random_polygon();
      shape_kind_type shape;
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 25) shape = SHAPE_WIDE;
      else if (r < 55) shape = SHAPE_LOCAL;
      else if (r < 65) shape = SHAPE_LINE;
      else if (r < 75) shape = SHAPE_CORNER;
      else shape = SHAPE_BOX;
      r = $urandom_range(0, 99);
      if (shape == SHAPE_BOX) n = 4;
      else if (r < 8) n = $urandom_range(1, 2);
      else if (r < 90) n = $urandom_range(3, 8);
      else n = $urandom_range(9, 40);
      send_polygon(shape, n);
      small_items += n;
   endtask

   initial begin : receiver
      rsp_type got;
      bit      taken;
      wait (!reset);
      forever begin
         @(negedge clock);
         taken = rsp_valid && !rsp_stall;
         got = rsp_data;
         @(posedge clock);
         if (taken) centroids.check_centroid(got);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single vertex, two vertices
      send_vertex(100, -100, 1'b1);
      send_vertex(-5, 7, 1'b0);
      send_vertex(300, 9, 1'b1);
      // counterclockwise and clockwise right triangles
      send_vertex(0, 0, 1'b0);
      send_vertex(48, 0, 1'b0);
      send_vertex(0, 48, 1'b1);
      send_vertex(0, 0, 1'b0);
      send_vertex(0, 48, 1'b0);
      send_vertex(48, 0, 1'b1);
      // collinear, zero area
      send_vertex(-32, -32, 1'b0);
      send_vertex(16, 16, 1'b0);
      send_vertex(64, 64, 1'b1);
      // full-scale triangle
      send_vertex(-32768, -32768, 1'b0);
      send_vertex(32767, -32768, 1'b0);
      send_vertex(32767, 32767, 1'b1);
      // self-intersecting quad whose centroid saturates
      send_vertex(0, 0, 1'b0);
      send_vertex(32767, 32767, 1'b0);
      send_vertex(32767, 0, 1'b0);
      send_vertex(0, 32766, 1'b1);
      wait_for_centroids();

      for (int phase = 0; phase < 4; phase++) begin
         steady = (phase == 2);
         while (small_items < (phase + 1) * SMALL_GOAL / 4) send_random_polygon();
         case (phase)
            0: begin
               send_polygon(SHAPE_WIDE, MAX_VERTICES + 1);
            end
            1: begin
               hold_left = HOLD_CYCLES;
               repeat (12) send_random_polygon();
            end
            2: wait_for_centroids();
            default: ;
         endcase
      end

      wait_for_centroids();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (centroids.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
